FILE: rtl/csvfs_pkg.sv
// Shared types, constants and helpers of the CSV field splitter.
package csvfs_pkg;

  // Default configuration
  localparam int unsigned MaxLineBytesDef = 65535;
  localparam int unsigned MaxFieldsDef    = 32;

  localparam int unsigned OffW   = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned IdxW   = 2;

  localparam logic [7:0]        SepReset   = 8'h2C; // comma
  localparam logic [7:0]        QuoteReset = 8'h22; // double quote
  localparam logic [CountW-1:0] ExpReset   = '0;
  localparam logic [7:0]        Backslash  = 8'h5C;
  localparam logic [CountW-1:0] CountMax   = '1;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_SEPARATOR = 2'd0,
    REG_QUOTE     = 2'd1,
    REG_EXPECTED  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_UNQUOTED = 3'd1,
    PH_QUOTED   = 3'd2,
    PH_PENDING  = 3'd3,
    PH_REST     = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [OffW-1:0]   pos;
    logic [OffW-1:0]   fstart;
    logic [CountW-1:0] nfields;
    logic              qtog;
    logic              prev_bs;
    logic [OffW-1:0]   qpos;
  } parse_st_t;

  localparam parse_st_t StClear = '{
    phase:   PH_START,
    pos:     '0,
    fstart:  '0,
    nfields: '0,
    qtog:    1'b0,
    prev_bs: 1'b0,
    qpos:    '0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
    logic       line_empty;
  } in_item_t;

  typedef struct packed {
    logic [OffW-1:0] field_start;
    logic [OffW-1:0] field_end;
    logic            is_filler;
    logic            last_of_line;
  } rec_t;

  // Outcome of taking one byte
  typedef struct packed {
    parse_st_t       st;
    logic            rec_v;
    logic [OffW-1:0] rec_start;
    logic [OffW-1:0] rec_end;
  } take_res_t;

  // Outcome of closing the line
  typedef struct packed {
    parse_st_t       st;
    logic [OffW-1:0] rec_start;
    logic [OffW-1:0] rec_end;
    logic            pad_more;
  } fin_res_t;

  // Offset increment, held at the line bound
  function automatic logic [OffW-1:0] sat_inc(logic [OffW-1:0] v, logic [OffW-1:0] bound);
    logic [OffW-1:0] r;
    r = (v >= bound) ? bound : v + 1'b1;
    return r;
  endfunction

  // Field count increment, held at the top of the counter
  function automatic logic [CountW-1:0] cnt_inc(logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = (v == CountMax) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/csvfs_if.sv
// Stream channels of the CSV field splitter: byte input and field record output.
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_line;
  logic       line_empty;

  modport source (output valid, data_byte, end_of_line, line_empty, input ready);
  modport sink   (input valid, data_byte, end_of_line, line_empty, output ready);
endinterface

interface csvfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] field_start;
  logic [15:0] field_end;
  logic        is_filler;
  logic        last_of_line;

  modport source (output valid, field_start, field_end, is_filler, last_of_line,
                  input ready);
  modport sink   (input valid, field_start, field_end, is_filler, last_of_line,
                  output ready);
endinterface

FILE: rtl/csvfs_parse_logic.sv
// Next-state logic of the splitter: one byte step and the end-of-line close.
module csvfs_parse_logic #(
  parameter int unsigned MAX_LINE_BYTES = csvfs_pkg::MaxLineBytesDef
) (
  input  logic [7:0]                    sep_i,
  input  logic [7:0]                    quote_i,
  input  logic [csvfs_pkg::CountW-1:0]  limit_i,
  input  csvfs_pkg::parse_st_t          st_i,
  input  logic [7:0]                    byte_i,
  input  logic                          apply_take_i,
  output csvfs_pkg::take_res_t          take_o,
  output csvfs_pkg::fin_res_t           fin_o
);

  localparam logic [csvfs_pkg::OffW-1:0] Bound = csvfs_pkg::OffW'(MAX_LINE_BYTES);

  logic                          is_sep;
  logic                          is_quote;
  logic                          u_tog;
  logic [csvfs_pkg::OffW-1:0]    u_fs;
  logic                          at_limit;
  csvfs_pkg::parse_st_t          fst;

  assign is_sep   = (byte_i == sep_i);
  assign is_quote = (byte_i == quote_i);
  // unquoted handling sees a fresh field when it starts here
  assign u_tog    = (st_i.phase == csvfs_pkg::PH_START) ? 1'b0 : st_i.qtog;
  assign u_fs     = (st_i.phase == csvfs_pkg::PH_START) ? st_i.pos : st_i.fstart;
  assign at_limit = ({1'b0, st_i.nfields} + 7'd1) == {1'b0, limit_i};

  // One byte step
  always_comb begin
    take_o           = '0;
    take_o.st        = st_i;
    take_o.rec_start = u_fs;
    take_o.rec_end   = st_i.pos;
    unique case (st_i.phase)
      csvfs_pkg::PH_START, csvfs_pkg::PH_UNQUOTED: begin
        take_o.st.fstart = u_fs;
        if (st_i.phase == csvfs_pkg::PH_START && is_quote) begin
          take_o.st.phase = csvfs_pkg::PH_QUOTED;
        end else begin
          take_o.st.phase = csvfs_pkg::PH_UNQUOTED;
          take_o.st.qtog  = u_tog;
          if (is_sep && !u_tog) begin
            if (at_limit) begin
              take_o.st.phase = csvfs_pkg::PH_REST;
            end else begin
              take_o.rec_v    = 1'b1;
              take_o.st.phase = csvfs_pkg::PH_START;
            end
          end else if (is_quote) begin
            take_o.st.qtog = ~u_tog;
          end
        end
      end
      csvfs_pkg::PH_QUOTED: begin
        if (is_quote && !st_i.prev_bs) begin
          take_o.st.phase = csvfs_pkg::PH_PENDING;
          take_o.st.qpos  = st_i.pos;
        end
      end
      csvfs_pkg::PH_PENDING: begin
        if (is_quote) begin
          take_o.st.phase = csvfs_pkg::PH_QUOTED;
        end else if (is_sep) begin
          take_o.rec_v     = 1'b1;
          take_o.rec_start = csvfs_pkg::sat_inc(st_i.fstart, Bound);
          take_o.rec_end   = st_i.qpos;
          take_o.st.phase  = csvfs_pkg::PH_START;
        end else begin
          take_o.st.phase = csvfs_pkg::PH_UNQUOTED;
          take_o.st.qtog  = 1'b0;
        end
      end
      default: begin
      end
    endcase
    take_o.st.prev_bs = (byte_i == csvfs_pkg::Backslash);
    take_o.st.pos     = csvfs_pkg::sat_inc(st_i.pos, Bound);
    if (take_o.rec_v) begin
      take_o.st.nfields = csvfs_pkg::cnt_inc(st_i.nfields);
    end
  end

  // Line close, on the state after this byte if it was taken
  assign fst = apply_take_i ? take_o.st : st_i;

  always_comb begin
    logic pad;
    pad              = 1'b1;
    fin_o            = '0;
    fin_o.st         = fst;
    fin_o.st.nfields = csvfs_pkg::cnt_inc(fst.nfields);
    fin_o.rec_start  = fst.fstart;
    fin_o.rec_end    = fst.pos;
    unique case (fst.phase)
      csvfs_pkg::PH_START: begin
        fin_o.rec_start = fst.pos;
      end
      csvfs_pkg::PH_UNQUOTED: begin
      end
      csvfs_pkg::PH_QUOTED: begin
        fin_o.rec_start = csvfs_pkg::sat_inc(fst.fstart, Bound);
      end
      csvfs_pkg::PH_PENDING: begin
        fin_o.rec_start = csvfs_pkg::sat_inc(fst.fstart, Bound);
        fin_o.rec_end   = fst.qpos;
      end
      default: begin
        pad = 1'b0;
      end
    endcase
    fin_o.pad_more = pad && (fin_o.st.nfields < limit_i);
  end

endmodule

FILE: rtl/csvfs_out_reg.sv
// Output register of the splitter: holds one field record until transferred.
module csvfs_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  csvfs_pkg::rec_t      rec_i,
  output logic                 free_o,
  csvfs_out_if.source          out_o
);

  logic            valid_q;
  csvfs_pkg::rec_t rec_q;

  // slot can be refilled in the cycle its record is transferred
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.field_start  = rec_q.field_start;
  assign out_o.field_end    = rec_q.field_end;
  assign out_o.is_filler    = rec_q.is_filler;
  assign out_o.last_of_line = rec_q.last_of_line;

endmodule

FILE: rtl/csv_field_splitter.sv
// CSV field splitter: takes one byte of a text line per transfer and returns a record per
// field (start offset, end offset, filler mark, end-of-line mark). A byte goes from the
// input register through the parse logic into the output register. One byte is taken per
// cycle while the output register is free and the byte gives at most one record; a byte
// that closes a field and ends the line stays in the input register until both records
// are pushed, and the last byte of a padded line until every filler record is pushed, as
// the output register takes one record per cycle while free. Separator, quote and field
// limit are to be written through the configuration port only while no line is in flight;
// the block itself does not enforce this. There is no clearing pass after reset.
module csv_field_splitter #(
  parameter int unsigned MAX_LINE_BYTES = csvfs_pkg::MaxLineBytesDef,
  parameter int unsigned MAX_FIELDS     = csvfs_pkg::MaxFieldsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csvfs_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [csvfs_pkg::CfgW-1:0]    cfg_data_i,
  csvfs_in_if.sink                      in_i,
  csvfs_out_if.source                   out_o
);

  localparam logic [csvfs_pkg::CountW-1:0] MaxFieldsC = csvfs_pkg::CountW'(MAX_FIELDS);

  logic [7:0]                    sep_q;
  logic [7:0]                    quote_q;
  logic [csvfs_pkg::CountW-1:0]  exp_q;
  logic [csvfs_pkg::CountW-1:0]  limit;

  csvfs_pkg::parse_st_t          st_q, st_d;
  csvfs_pkg::in_item_t           stg_q;
  logic                          stg_valid_q;
  logic                          byte_done_q, byte_done_d;
  logic                          fill_q, fill_d;

  csvfs_pkg::take_res_t          take;
  csvfs_pkg::fin_res_t           fin;
  logic                          take_pending;
  logic                          need_fin;
  logic                          consume;
  logic                          push;
  csvfs_pkg::rec_t               rec;
  logic                          slot_free;
  logic [csvfs_pkg::CountW-1:0]  fill_cnt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= csvfs_pkg::SepReset;
      quote_q <= csvfs_pkg::QuoteReset;
      exp_q   <= csvfs_pkg::ExpReset;
    end else if (cfg_we_i) begin
      unique case (csvfs_pkg::reg_idx_e'(cfg_idx_i))
        csvfs_pkg::REG_SEPARATOR: sep_q   <= cfg_data_i[7:0];
        csvfs_pkg::REG_QUOTE:     quote_q <= cfg_data_i[7:0];
        csvfs_pkg::REG_EXPECTED:  exp_q   <= cfg_data_i[csvfs_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign limit = (exp_q > MaxFieldsC) ? MaxFieldsC : exp_q;

  csvfs_parse_logic #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_parse (
    .sep_i        (sep_q),
    .quote_i      (quote_q),
    .limit_i      (limit),
    .st_i         (st_q),
    .byte_i       (stg_q.data_byte),
    .apply_take_i (take_pending),
    .take_o       (take),
    .fin_o        (fin)
  );

  csvfs_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .free_o (slot_free),
    .out_o  (out_o)
  );

  assign take_pending = !byte_done_q && !stg_q.line_empty;
  assign need_fin     = stg_q.end_of_line || stg_q.line_empty;
  assign fill_cnt     = csvfs_pkg::cnt_inc(st_q.nfields);

  // Record sequencing for the byte in the input register
  always_comb begin
    st_d        = st_q;
    byte_done_d = byte_done_q;
    fill_d      = fill_q;
    consume     = 1'b0;
    push        = 1'b0;
    rec         = '0;
    if (stg_valid_q) begin
      priority if (fill_q) begin
        // padding records
        if (slot_free) begin
          push             = 1'b1;
          rec.is_filler    = 1'b1;
          rec.last_of_line = (fill_cnt >= limit);
          st_d.nfields     = fill_cnt;
          if (rec.last_of_line) begin
            st_d    = csvfs_pkg::StClear;
            consume = 1'b1;
          end
        end
      end else if (take_pending && take.rec_v) begin
        // field closed by a separator
        if (slot_free) begin
          push            = 1'b1;
          rec.field_start = take.rec_start;
          rec.field_end   = take.rec_end;
          st_d            = take.st;
          if (need_fin) begin
            byte_done_d = 1'b1;
          end else begin
            consume = 1'b1;
          end
        end
      end else if (need_fin) begin
        // final field of the line
        if (slot_free) begin
          push             = 1'b1;
          rec.field_start  = fin.rec_start;
          rec.field_end    = fin.rec_end;
          rec.last_of_line = !fin.pad_more;
          if (fin.pad_more) begin
            st_d        = fin.st;
            fill_d      = 1'b1;
            byte_done_d = 1'b1;
          end else begin
            st_d    = csvfs_pkg::StClear;
            consume = 1'b1;
          end
        end
      end else begin
        // byte with no record
        st_d    = take.st;
        consume = 1'b1;
      end
    end
    if (consume) begin
      byte_done_d = 1'b0;
      fill_d      = 1'b0;
    end
  end

  assign in_i.ready = !stg_valid_q || consume;

  // Parse state and input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= csvfs_pkg::StClear;
      stg_valid_q <= 1'b0;
      byte_done_q <= 1'b0;
      fill_q      <= 1'b0;
    end else begin
      st_q        <= st_d;
      byte_done_q <= byte_done_d;
      fill_q      <= fill_d;
      if (in_i.valid && in_i.ready) begin
        stg_valid_q <= 1'b1;
      end else if (consume) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_q.data_byte   <= in_i.data_byte;
      stg_q.end_of_line <= in_i.end_of_line;
      stg_q.line_empty  <= in_i.line_empty;
    end
  end

endmodule

FILE: dv/csv_field_splitter_tb.sv
// Self-checking testbench of the CSV field splitter: line stimulus, field predictor, record checks.
module csv_field_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 8;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [csvfs_pkg::IdxW-1:0] cfg_idx;
  logic [csvfs_pkg::CfgW-1:0] cfg_data;

  csvfs_in_if  in_ch ();
  csvfs_out_if out_ch ();

  csv_field_splitter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Configuration as the block should currently hold it
  logic [7:0]                   sep_cfg;
  logic [7:0]                   quote_cfg;
  logic [csvfs_pkg::CountW-1:0] limit_cfg;

  // Line parse state of the predictor
  csvfs_pkg::phase_e            line_phase;
  logic [csvfs_pkg::OffW-1:0]   line_pos;
  logic [csvfs_pkg::OffW-1:0]   field_begin;
  logic [csvfs_pkg::OffW-1:0]   quote_at;
  logic [csvfs_pkg::CountW-1:0] field_count;
  logic                         in_toggle;
  logic                         after_bs;

  csvfs_pkg::in_item_t byte_q[$];      // bytes waiting to be driven
  csvfs_pkg::rec_t     fields_due[$];  // predicted field records, oldest first
  csvfs_pkg::in_item_t cur_item;

  int  sent;
  int  queued;
  int  errors;
  int  cycle_count;
  int  send_wait;
  int  take_wait;
  bit  idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Field predictor
  // ---------------------------------------------------------------------------

  function automatic logic [csvfs_pkg::OffW-1:0] off_inc(logic [csvfs_pkg::OffW-1:0] v);
    return (v >= csvfs_pkg::OffW'(csvfs_pkg::MaxLineBytesDef)) ?
           csvfs_pkg::OffW'(csvfs_pkg::MaxLineBytesDef) : v + 1'b1;
  endfunction

  function automatic int field_limit();
    return (int'(limit_cfg) > int'(csvfs_pkg::MaxFieldsDef)) ?
           int'(csvfs_pkg::MaxFieldsDef) : int'(limit_cfg);
  endfunction

  task automatic reset_line();
    line_phase  = csvfs_pkg::PH_START;
    line_pos    = '0;
    field_begin = '0;
    quote_at    = '0;
    field_count = '0;
    in_toggle   = 1'b0;
    after_bs    = 1'b0;
  endtask

  task automatic push_field(logic [csvfs_pkg::OffW-1:0] s, logic [csvfs_pkg::OffW-1:0] e,
                            logic fill);
    csvfs_pkg::rec_t r;
    r.field_start  = s;
    r.field_end    = e;
    r.is_filler    = fill;
    r.last_of_line = 1'b0;
    fields_due.insert(fields_due.size(), r);
    if (field_count != csvfs_pkg::CountMax) field_count++;
  endtask

  // Byte inside an unquoted field: separator closes it unless hidden by quotes or the field limit is reached
  task automatic plain_byte(logic [7:0] b, logic [csvfs_pkg::OffW-1:0] p);
    if (b == sep_cfg && !in_toggle) begin
      if (int'(field_count) + 1 == field_limit()) begin
        line_phase = csvfs_pkg::PH_REST;
      end else begin
        push_field(field_begin, p, 1'b0);
        line_phase = csvfs_pkg::PH_START;
      end
    end else if (b == quote_cfg) begin
      in_toggle = ~in_toggle;
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [csvfs_pkg::OffW-1:0] p;
    p = line_pos;
    case (line_phase)
      csvfs_pkg::PH_START: begin
        field_begin = p;
        if (b == quote_cfg) begin
          line_phase = csvfs_pkg::PH_QUOTED;
        end else begin
          line_phase = csvfs_pkg::PH_UNQUOTED;
          in_toggle  = 1'b0;
          plain_byte(b, p);
        end
      end
      csvfs_pkg::PH_UNQUOTED: plain_byte(b, p);
      csvfs_pkg::PH_QUOTED: begin
        if (b == quote_cfg && !after_bs) begin
          line_phase = csvfs_pkg::PH_PENDING;
          quote_at   = p;
        end
      end
      csvfs_pkg::PH_PENDING: begin
        // quote seen: doubled quote, close on separator, or back to unquoted
        if (b == quote_cfg) begin
          line_phase = csvfs_pkg::PH_QUOTED;
        end else if (b == sep_cfg) begin
          push_field(off_inc(field_begin), quote_at, 1'b0);
          line_phase = csvfs_pkg::PH_START;
        end else begin
          line_phase = csvfs_pkg::PH_UNQUOTED;
          in_toggle  = 1'b0;
        end
      end
      default: ;
    endcase
    after_bs = (b == csvfs_pkg::Backslash);
    line_pos = off_inc(p);
  endtask

  task automatic close_line();
    logic pad;
    pad = 1'b1;
    case (line_phase)
      csvfs_pkg::PH_START:    push_field(line_pos, line_pos, 1'b0);
      csvfs_pkg::PH_UNQUOTED: push_field(field_begin, line_pos, 1'b0);
      csvfs_pkg::PH_QUOTED:   push_field(off_inc(field_begin), line_pos, 1'b0);
      csvfs_pkg::PH_PENDING:  push_field(off_inc(field_begin), quote_at, 1'b0);
      default: begin
        // limit field takes the rest of the line, no padding
        push_field(field_begin, line_pos, 1'b0);
        pad = 1'b0;
      end
    endcase
    if (pad) begin
      while (int'(field_count) < field_limit()) push_field('0, '0, 1'b1);
    end
    fields_due[fields_due.size()-1].last_of_line = 1'b1;
    reset_line();
  endtask

  task automatic split_item(csvfs_pkg::in_item_t it);
    if (!it.line_empty) take_byte(it.data_byte);
    if (it.end_of_line || it.line_empty) close_line();
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_error(string what, int unsigned got_v, int unsigned want_v);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got_v, want_v);
    end
  endtask

  // Byte driver: one item per transfer, random wait between items when gaps are enabled
  always @(posedge clk) begin : feed_bytes
    logic fire;
    logic drive_v;
    fire    = in_ch.valid && in_ch.ready;
    drive_v = in_ch.valid && !fire;
    if (!rst_n) begin
      drive_v = 1'b0;
      reset_line();
    end else begin
      if (fire) begin
        split_item(cur_item);
        sent++;
      end
      if (!drive_v) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (byte_q.size() != 0) begin
          cur_item = byte_q.pop_front();
          in_ch.data_byte   <= cur_item.data_byte;
          in_ch.end_of_line <= cur_item.end_of_line;
          in_ch.line_empty  <= cur_item.line_empty;
          drive_v   = 1'b1;
          send_wait = idle_on ? $urandom_range(0, 8) : 0;
        end
      end
    end
    in_ch.valid <= drive_v;
  end

  // Record monitor: compares each transfer with the oldest prediction
  always @(posedge clk) begin : check_fields
    csvfs_pkg::rec_t got;
    csvfs_pkg::rec_t want;
    logic take_r;
    if (!rst_n) begin
      take_r = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.field_start, out_ch.field_end, out_ch.is_filler, out_ch.last_of_line};
        if (fields_due.size() == 0) begin
          report_error("record with nothing expected, field_start",
                       32'(got.field_start), 0);
        end else begin
          want = fields_due.pop_front();
          if (got.field_start != want.field_start)
            report_error("field_start", 32'(got.field_start), 32'(want.field_start));
          if (got.field_end != want.field_end)
            report_error("field_end", 32'(got.field_end), 32'(want.field_end));
          if (got.is_filler != want.is_filler)
            report_error("is_filler", 32'(got.is_filler), 32'(want.is_filler));
          if (got.last_of_line != want.last_of_line)
            report_error("last_of_line", 32'(got.last_of_line), 32'(want.last_of_line));
        end
        take_wait = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (take_wait > 0) begin
        take_wait--;
        take_r = 1'b0;
      end else begin
        take_r = 1'b1;
      end
    end
    out_ch.ready <= take_r;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic [7:0] b, logic eol, logic empty);
    csvfs_pkg::in_item_t it;
    it.data_byte   = b;
    it.end_of_line = eol;
    it.line_empty  = empty;
    byte_q.insert(byte_q.size(), it);
    queued++;
  endtask

  task automatic queue_text(string s);
    if (s.len() == 0) begin
      queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) queue_item(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Bytes weighted towards the ones the parser reacts to
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return sep_cfg;
      3, 4:    return quote_cfg;
      5:       return csvfs_pkg::Backslash;
      6, 7:    return 8'($urandom_range(97, 122));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed lines; some cut short by an empty-line marker
  task automatic queue_random_line();
    int len;
    bit cut;
    len = $urandom_range(0, 12);
    cut = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) queue_item(pick_byte(), !cut && (i == len - 1), 1'b0);
    if (len == 0 || cut) queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic write_reg(csvfs_pkg::reg_idx_e idx, logic [7:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      csvfs_pkg::REG_SEPARATOR: sep_cfg   = val;
      csvfs_pkg::REG_QUOTE:     quote_cfg = val;
      csvfs_pkg::REG_EXPECTED:  limit_cfg = val[csvfs_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  // Wait until every byte is taken and every record has arrived
  task automatic drain();
    while (sent != queued || fields_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] sep, logic [7:0] quo, logic [5:0] lim, int n_items,
                           bit gaps);
    int target;
    drain();
    write_reg(csvfs_pkg::REG_SEPARATOR, sep);
    write_reg(csvfs_pkg::REG_QUOTE, quo);
    write_reg(csvfs_pkg::REG_EXPECTED, {2'b00, lim});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    idle_on = gaps;
    target  = queued + n_items;
    while (queued < target) queue_random_line();
  endtask

  initial begin : stimulus
    cfg_we   = 1'b0;
    cfg_idx  = csvfs_pkg::REG_SEPARATOR;
    cfg_data = '0;
    rst_n    = 1'b0;
    sep_cfg   = csvfs_pkg::SepReset;
    quote_cfg = csvfs_pkg::QuoteReset;
    limit_cfg = csvfs_pkg::ExpReset;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines under reset settings
    queue_text("\"\\\"\"\"\",x");  // escaped quote, doubled quote, close on separator
    queue_text("\"q\"a\"b,c");     // quote then other byte, toggle hides separator
    queue_text(",");               // trailing separator gives empty final field
    queue_text("");                // empty line
    queue_text("\"o");             // quote never closed
    queue_item("a", 1'b0, 1'b0);   // line cut by empty marker without end of line
    queue_item("b", 1'b0, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b1);
    queue_text("\"x\"");           // line ends right after closing quote

    // Random lines under a spread of settings
    run_phase(",", "\"", 6'd3, 35, 1'b1);
    run_phase(8'h00, 8'hFF, 6'd1, 35, 1'b0);
    run_phase(8'hFF, 8'h00, 6'd63, 15, 1'b1);   // limit above the field maximum
    run_phase(";", ";", 6'd2, 35, 1'b1);        // separator equal to quote
    run_phase(",", "\"", 6'd32, 15, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              6'($urandom_range(0, 6)), 40, 1'b1);

    // Field count past the counter top
    run_phase(",", "\"", 6'd0, 0, 1'b0);
    write_reg(csvfs_pkg::REG_UNUSED, 8'($urandom_range(0, 255)));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    repeat (69) queue_item(",", 1'b0, 1'b0);
    queue_item(",", 1'b1, 1'b0);
    queue_text(",a,\"b\",c");

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
